// File: rtl/rotate_translate_scale_points_defines.svh
// assertion macros used by the top rts module
`ifndef ROTATE_TRANSLATE_SCALE_POINTS_DEFINES_SVH
`define ROTATE_TRANSLATE_SCALE_POINTS_DEFINES_SVH
`ifndef SYNTH
`define RTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rts assertion failed");
`define RTS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("rts assertion failed");
`else
`define RTS_ASSERT(lbl, prop)
`define RTS_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/rts_pkg.sv
`timescale 1ns / 1ps
package rts_pkg;

  localparam int DW   = 32;       // data word, Q16.16
  localparam int OPW  = DW + 1;   // multiplier operand
  localparam int ACCW = 2 * OPW;  // product and accumulator
  localparam int AW   = 16;       // angle, Q3.12

  localparam int CORDIC_STEPS = 16;
  localparam int ITW = 5;
  localparam int CXW = 33;
  localparam int CZW = 29;

  localparam logic signed [DW-1:0]  ONE_Q16     = 32'sd65536;
  localparam logic signed [CXW-1:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [CZW-1:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [CZW-1:0] TWO_PI_Q24  = 29'sd105414358;
  localparam logic signed [CZW-1:0] HALF_PI_Q24 = 29'sd26353589;

  localparam int CFG_IDXW = 3;
  localparam logic [CFG_IDXW-1:0] REG_OFFSET_X  = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_OFFSET_Y  = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_OFFSET_Z  = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_SCALE     = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_VECTOR_EN = 3'd4;

  // operand source codes
  localparam int SRCW = 6;
  localparam logic [SRCW-1:0] SRC_TRIG0 = 6'd0;   // ca sa cb sb cc sc
  localparam logic [SRCW-1:0] SRC_TU0   = 6'd6;   // t u
  localparam logic [SRCW-1:0] SRC_INC0  = 6'd8;
  localparam logic [SRCW-1:0] SRC_M0    = 6'd17;
  localparam logic [SRCW-1:0] SRC_D0    = 6'd26;
  localparam logic [SRCW-1:0] SRC_V0    = 6'd29;
  localparam logic [SRCW-1:0] SRC_SCALE = 6'd32;
  localparam logic [SRCW-1:0] SRC_ROT0  = 6'd33;
  localparam logic [SRCW-1:0] SRC_CA = SRC_TRIG0;
  localparam logic [SRCW-1:0] SRC_SA = SRC_TRIG0 + 6'd1;
  localparam logic [SRCW-1:0] SRC_CB = SRC_TRIG0 + 6'd2;
  localparam logic [SRCW-1:0] SRC_SB = SRC_TRIG0 + 6'd3;
  localparam logic [SRCW-1:0] SRC_CC = SRC_TRIG0 + 6'd4;
  localparam logic [SRCW-1:0] SRC_SC = SRC_TRIG0 + 6'd5;
  localparam logic [SRCW-1:0] SRC_T  = SRC_TU0;
  localparam logic [SRCW-1:0] SRC_U  = SRC_TU0 + 6'd1;

  // result destination codes
  localparam int DSTW = 5;
  localparam logic [DSTW-1:0] DST_TU0  = 5'd0;
  localparam logic [DSTW-1:0] DST_INC0 = 5'd2;
  localparam logic [DSTW-1:0] DST_NM0  = 5'd11;
  localparam logic [DSTW-1:0] DST_ROT0 = 5'd20;
  localparam logic [DSTW-1:0] DST_OUT0 = 5'd23;
  localparam logic [DSTW-1:0] DST_NONE = 5'd31;

  localparam int STW = 6;
  localparam logic [STW-1:0] PT_END  = 6'd21;
  localparam logic [STW-1:0] ROT_END = 6'd42;

  typedef struct packed {
    logic            vld;
    logic [SRCW-1:0] a;
    logic            neg;
    logic [SRCW-1:0] b;
    logic            first;
    logic            last;
    logic [DSTW-1:0] dst;
  } uop_t;

  typedef struct packed {
    logic            vld;
    logic            first;
    logic            last;
    logic [DSTW-1:0] dst;
  } mac_ctl_t;

  function automatic logic signed [CZW-1:0] atan_q24(input logic [ITW-1:0] i);
    logic signed [CZW-1:0] r;
    case (i)
      5'd0:  r = 29'sd13176795;
      5'd1:  r = 29'sd7778716;
      5'd2:  r = 29'sd4110060;
      5'd3:  r = 29'sd2086331;
      5'd4:  r = 29'sd1047214;
      5'd5:  r = 29'sd524117;
      5'd6:  r = 29'sd262123;
      5'd7:  r = 29'sd131069;
      5'd8:  r = 29'sd65536;
      5'd9:  r = 29'sd32768;
      5'd10: r = 29'sd16384;
      5'd11: r = 29'sd8192;
      5'd12: r = 29'sd4096;
      5'd13: r = 29'sd2048;
      5'd14: r = 29'sd1024;
      5'd15: r = 29'sd512;
      5'd16: r = 29'sd256;
      5'd17: r = 29'sd128;
      5'd18: r = 29'sd64;
      5'd19: r = 29'sd32;
      5'd20: r = 29'sd16;
      5'd21: r = 29'sd8;
      5'd22: r = 29'sd4;
      5'd23: r = 29'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic uop_t mk(input logic [SRCW-1:0] a, input logic neg,
                              input logic [SRCW-1:0] b, input logic first,
                              input logic last, input logic [DSTW-1:0] dst);
    uop_t u;
    u.vld   = 1'b1;
    u.a     = a;
    u.neg   = neg;
    u.b     = b;
    u.first = first;
    u.last  = last;
    u.dst   = dst;
    return u;
  endfunction

  // incremental matrix, then new = inc * m, one product per step
  function automatic uop_t rot_uop(input logic [STW-1:0] step);
    uop_t u;
    u = '0;
    u.dst = DST_NONE;
    case (step)
      6'd0:  u = mk(SRC_SA, 1'b0, SRC_SB, 1'b1, 1'b1, DST_TU0);
      6'd1:  u = mk(SRC_CA, 1'b0, SRC_SB, 1'b1, 1'b1, DST_TU0 + 5'd1);
      6'd2:  u = mk(SRC_CB, 1'b0, SRC_CC, 1'b1, 1'b1, DST_INC0);
      6'd3:  u = mk(SRC_CB, 1'b0, SRC_SC, 1'b1, 1'b1, DST_INC0 + 5'd1);
      6'd4:  u = mk(SRC_SA, 1'b0, SRC_CB, 1'b1, 1'b1, DST_INC0 + 5'd5);
      6'd5:  u = mk(SRC_CA, 1'b0, SRC_CB, 1'b1, 1'b1, DST_INC0 + 5'd8);
      6'd6:  u = mk(SRC_T,  1'b1, SRC_CC, 1'b1, 1'b0, DST_INC0 + 5'd3);
      6'd7:  u = mk(SRC_CA, 1'b1, SRC_SC, 1'b0, 1'b1, DST_INC0 + 5'd3);
      6'd8:  u = mk(SRC_T,  1'b1, SRC_SC, 1'b1, 1'b0, DST_INC0 + 5'd4);
      6'd9:  u = mk(SRC_CA, 1'b0, SRC_CC, 1'b0, 1'b1, DST_INC0 + 5'd4);
      6'd10: u = mk(SRC_U,  1'b1, SRC_CC, 1'b1, 1'b0, DST_INC0 + 5'd6);
      6'd11: u = mk(SRC_SA, 1'b0, SRC_SC, 1'b0, 1'b1, DST_INC0 + 5'd6);
      6'd12: u = mk(SRC_U,  1'b1, SRC_SC, 1'b1, 1'b0, DST_INC0 + 5'd7);
      6'd13: u = mk(SRC_SA, 1'b1, SRC_CC, 1'b0, 1'b1, DST_INC0 + 5'd7);
      default: begin
        for (int jj = 0; jj < 3; jj++) begin
          for (int ii = 0; ii < 3; ii++) begin
            for (int kk = 0; kk < 3; kk++) begin
              if (step == STW'(14 + jj * 9 + ii * 3 + kk)) begin
                u = mk(SRCW'(SRC_INC0 + jj * 3 + kk), 1'b0, SRCW'(SRC_M0 + kk * 3 + ii),
                       kk == 0, kk == 2, DSTW'(DST_NM0 + jj * 3 + ii));
              end
            end
          end
        end
      end
    endcase
    return u;
  endfunction

  function automatic uop_t pt_uop(input logic [STW-1:0] step);
    uop_t u;
    u = '0;
    u.dst = DST_NONE;
    for (int jj = 0; jj < 3; jj++) begin
      for (int kk = 0; kk < 3; kk++) begin
        if (step == STW'(jj * 3 + kk)) begin
          u = mk(SRCW'(SRC_M0 + jj * 3 + kk), 1'b0, SRCW'(SRC_D0 + kk),
                 kk == 0, kk == 2, DSTW'(DST_ROT0 + jj));
        end
        if (step == STW'(9 + jj * 3 + kk)) begin
          u = mk(SRCW'(SRC_M0 + jj * 3 + kk), 1'b0, SRCW'(SRC_V0 + kk),
                 kk == 0, kk == 2, DSTW'(DST_OUT0 + 3 + jj));
        end
      end
      if (step == STW'(18 + jj)) begin
        u = mk(SRC_SCALE, 1'b0, SRCW'(SRC_ROT0 + jj), 1'b1, 1'b1, DSTW'(DST_OUT0 + jj));
      end
    end
    return u;
  endfunction

endpackage

// File: rtl/rts_in_if.sv
`timescale 1ns / 1ps
interface rts_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               reset_first;
  logic signed [15:0] angle_a;
  logic signed [15:0] angle_b;
  logic signed [15:0] angle_c;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (output valid, func, reset_first, angle_a, angle_b, angle_c,
                  pos_x, pos_y, pos_z, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, func, reset_first, angle_a, angle_b, angle_c,
                pos_x, pos_y, pos_z, vec_x, vec_y, vec_z, output ready);
endinterface

// File: rtl/rts_out_if.sv
`timescale 1ns / 1ps
interface rts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_vx;
  logic signed [31:0] out_vy;
  logic signed [31:0] out_vz;

  modport source (output valid, out_x, out_y, out_z, out_vx, out_vy, out_vz, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_vx, out_vy, out_vz, output ready);
endinterface

// File: rtl/rotate_translate_scale_points.sv
`timescale 1ns / 1ps
// Rotate, translate and scale points in Q16.16 with a stored 3x3 rotation matrix.
// in_i carries one item per transaction: func 1 is a rotate item (three Q3.12
// Euler angles, optional matrix reset to identity first), func 0 a point item.
// A point item yields one transaction on out_o: offset-subtracted, rotated and
// scaled position, plus the rotated vector when vector mode is on (else zeros).
// Rotate items yield nothing. The user must write registers through cfg_we_i/
// cfg_idx_i/cfg_data_i only while idle (the block itself does not enforce it);
// unknown indexes are dropped. All products go through one shared 33x33
// multiply-accumulate unit, one term a cycle; sines and cosines come from one
// iterative CORDIC, one step a cycle. A point item runs 21 products and the
// two-stage multiply-accumulate drain before out_o turns valid. A rotate item
// needs three CORDIC runs, then its products and the matrix update.
// in_i is ready only between items. A finished result waits in the output register
// while the next item is taken; if the receiver stalls, a following point item
// holds in ST_OUT after its last step until the output register frees.
// Reset gives the identity matrix, zero offsets, scale 1.0, vector mode off and
// an empty output register.
module rotate_translate_scale_points import rts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  rts_in_if.sink              in_i,
  rts_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [DW-1:0]       cfg_data_i
);
  `include "rotate_translate_scale_points_defines.svh"

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SINCOS = 2'd1;
  localparam logic [1:0] ST_MAC    = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [STW-1:0]       step_q, step_d;
  logic [1:0]           ang_q, ang_d;
  logic                 start_q, start_d;
  logic                 func_q, func_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept, out_load, do_copy;

  logic signed [DW-1:0] off_q [3];
  logic [DW-2:0]        scale_q;
  logic                 vec_en_q;
  logic signed [DW-1:0] m_q   [9];
  logic signed [DW-1:0] nm_q  [9];
  logic signed [DW-1:0] trig_q [6];
  logic signed [DW-1:0] tu_q  [2];
  logic signed [DW-1:0] inc_q [9];
  logic signed [DW-1:0] d_q   [3];
  logic signed [DW-1:0] v_q   [3];
  logic signed [DW-1:0] rot_q [3];
  logic signed [DW-1:0] res_q [6];
  logic signed [DW-1:0] outd_q [6];
  logic signed [AW-1:0] ang_a_q, ang_b_q, ang_c_q, cor_angle;
  logic signed [DW-1:0] pos_in [3];
  logic signed [DW:0]   diff [3];
  logic signed [DW-1:0] dsat [3];

  logic                 cor_done;
  logic signed [DW-1:0] cor_cos, cor_sin;
  uop_t                 uop;
  mac_ctl_t             mac_ctl, mac_wr;
  logic signed [OPW-1:0] opa, opb;
  logic signed [DW-1:0] mac_res;

  function automatic logic signed [OPW-1:0] pick(input logic [SRCW-1:0] code);
    logic signed [DW-1:0] v;
    v = '0;
    for (int n = 0; n < 9; n++) begin
      if (code == SRCW'(SRC_INC0 + n)) v = inc_q[n];
      if (code == SRCW'(SRC_M0 + n))   v = m_q[n];
    end
    for (int n = 0; n < 6; n++) begin
      if (code == SRCW'(SRC_TRIG0 + n)) v = trig_q[n];
    end
    for (int n = 0; n < 3; n++) begin
      if (code == SRCW'(SRC_D0 + n))   v = d_q[n];
      if (code == SRCW'(SRC_V0 + n))   v = v_q[n];
      if (code == SRCW'(SRC_ROT0 + n)) v = rot_q[n];
    end
    for (int n = 0; n < 2; n++) begin
      if (code == SRCW'(SRC_TU0 + n)) v = tu_q[n];
    end
    if (code == SRC_SCALE) begin
      return {2'b00, scale_q};
    end
    return {v[DW-1], v};
  endfunction

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign do_copy  = (state_q == ST_MAC) && func_q && (step_q == ROT_END);

  assign pos_in[0] = in_i.pos_x;
  assign pos_in[1] = in_i.pos_y;
  assign pos_in[2] = in_i.pos_z;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      diff[n] = {pos_in[n][DW-1], pos_in[n]} - {off_q[n][DW-1], off_q[n]};
      if (diff[n][DW] != diff[n][DW-1]) begin
        dsat[n] = diff[n][DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        dsat[n] = diff[n][DW-1:0];
      end
    end
  end

  always_comb begin
    case (ang_q)
      2'd0:    cor_angle = ang_a_q;
      2'd1:    cor_angle = ang_b_q;
      default: cor_angle = ang_c_q;
    endcase
  end

  always_comb begin
    uop = '0;
    if (state_q == ST_MAC) begin
      uop = func_q ? rot_uop(step_q) : pt_uop(step_q);
    end
    mac_ctl.vld   = uop.vld;
    mac_ctl.first = uop.first;
    mac_ctl.last  = uop.last;
    mac_ctl.dst   = uop.dst;
    opa = uop.neg ? -pick(uop.a) : pick(uop.a);
    opb = pick(uop.b);
  end

  rts_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  rts_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (opa),
    .b_i    (opb),
    .wr_o   (mac_wr),
    .res_o  (mac_res)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ang_d       = ang_q;
    start_d     = 1'b0;
    func_d      = func_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d = in_i.func;
          step_d = '0;
          ang_d  = 2'd0;
          if (in_i.func) begin
            state_d = ST_SINCOS;
            start_d = 1'b1;
          end else begin
            state_d = ST_MAC;
          end
        end
      end
      ST_SINCOS: begin
        if (cor_done) begin
          if (ang_q == 2'd2) begin
            state_d = ST_MAC;
          end else begin
            ang_d   = ang_q + 2'd1;
            start_d = 1'b1;
          end
        end
      end
      ST_MAC: begin
        step_d = step_q + 1'b1;
        if (func_q && step_q == ROT_END) begin
          state_d = ST_IDLE;
        end else if (!func_q && step_q == PT_END) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      ang_q       <= '0;
      start_q     <= 1'b0;
      func_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ang_q       <= ang_d;
      start_q     <= start_d;
      func_q      <= func_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration and matrix state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 3; n++) off_q[n] <= '0;
      scale_q  <= ONE_Q16[DW-2:0];
      vec_en_q <= 1'b0;
      for (int n = 0; n < 9; n++) m_q[n] <= (n % 4 == 0) ? ONE_Q16 : '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OFFSET_X:  off_q[0] <= cfg_data_i;
          REG_OFFSET_Y:  off_q[1] <= cfg_data_i;
          REG_OFFSET_Z:  off_q[2] <= cfg_data_i;
          REG_SCALE:     scale_q  <= cfg_data_i[DW-2:0];
          REG_VECTOR_EN: vec_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept && in_i.func && in_i.reset_first) begin
        for (int n = 0; n < 9; n++) m_q[n] <= (n % 4 == 0) ? ONE_Q16 : '0;
      end
      if (do_copy) begin
        for (int n = 0; n < 9; n++) m_q[n] <= nm_q[n];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ang_a_q <= in_i.angle_a;
      ang_b_q <= in_i.angle_b;
      ang_c_q <= in_i.angle_c;
      for (int n = 0; n < 3; n++) d_q[n] <= dsat[n];
      v_q[0] <= in_i.vec_x;
      v_q[1] <= in_i.vec_y;
      v_q[2] <= in_i.vec_z;
    end
    if (state_q == ST_SINCOS && cor_done) begin
      trig_q[{ang_q, 1'b0}] <= cor_cos;
      trig_q[{ang_q, 1'b1}] <= cor_sin;
      if (ang_q == 2'd1) begin
        inc_q[2] <= cor_sin;
      end
    end
    if (mac_wr.vld) begin
      for (int n = 0; n < 2; n++) begin
        if (mac_wr.dst == DSTW'(DST_TU0 + n)) tu_q[n] <= mac_res;
      end
      for (int n = 0; n < 9; n++) begin
        if (n != 2 && mac_wr.dst == DSTW'(DST_INC0 + n)) inc_q[n] <= mac_res;
        if (mac_wr.dst == DSTW'(DST_NM0 + n)) nm_q[n] <= mac_res;
      end
      for (int n = 0; n < 3; n++) begin
        if (mac_wr.dst == DSTW'(DST_ROT0 + n)) rot_q[n] <= mac_res;
      end
      for (int n = 0; n < 6; n++) begin
        if (mac_wr.dst == DSTW'(DST_OUT0 + n)) res_q[n] <= mac_res;
      end
    end
    if (out_load) begin
      for (int n = 0; n < 3; n++) begin
        outd_q[n]     <= res_q[n];
        outd_q[3 + n] <= vec_en_q ? res_q[3 + n] : '0;
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.out_x  = outd_q[0];
  assign out_o.out_y  = outd_q[1];
  assign out_o.out_z  = outd_q[2];
  assign out_o.out_vx = outd_q[3];
  assign out_o.out_vy = outd_q[4];
  assign out_o.out_vz = outd_q[5];

  `RTS_ASSERT(a_cordic_in_sincos, cor_done |-> state_q == ST_SINCOS)
  `RTS_ASSERT(a_out_only_point, (mac_wr.vld && mac_wr.dst >= DST_OUT0) |-> !func_q)
  `RTS_ASSERT(a_step_bound, (state_q == ST_MAC) |-> step_q <= ROT_END)
  `RTS_ASSERT(a_busy_after_accept, accept |=> state_q != ST_IDLE)
  `RTS_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_o.valid)

endmodule

// File: rtl/rts_cordic.sv
`timescale 1ns / 1ps
module rts_cordic import rts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] angle_i,
  output logic                 done_o,
  output logic signed [DW-1:0] cos_o,
  output logic signed [DW-1:0] sin_o
);

  logic                  busy_q, rnd_q, done_q;
  logic [ITW-1:0]        iter_q;
  logic signed [CXW-1:0] x_q, y_q, dx, dy, xr, yr;
  logic signed [CZW-1:0] z_q, z0, zw, zf;
  logic                  neg_q, negf;
  logic signed [DW-1:0]  cos_q, sin_q;

  // wrap once by two pi, then fold into [-pi/2, pi/2]
  always_comb begin
    z0   = {angle_i[AW-1], angle_i, 12'b0};
    zw   = z0;
    zf   = z0;
    negf = 1'b0;
    if (z0 > PI_Q24) begin
      zw = z0 - TWO_PI_Q24;
    end else if (z0 < -PI_Q24) begin
      zw = z0 + TWO_PI_Q24;
    end
    zf = zw;
    if (zw > HALF_PI_Q24) begin
      zf   = zw - PI_Q24;
      negf = 1'b1;
    end else if (zw < -HALF_PI_Q24) begin
      zf   = zw + PI_Q24;
      negf = 1'b1;
    end
  end

  assign dx = y_q >>> iter_q;
  assign dy = x_q >>> iter_q;
  assign xr = (x_q + 33'sd8192) >>> 14;
  assign yr = (y_q + 33'sd8192) >>> 14;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && angle_i == '0) begin
        done_q <= 1'b1;
      end else if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          rnd_q  <= 1'b1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && angle_i == '0) begin
      cos_q <= ONE_Q16;
      sin_q <= '0;
    end else if (start_i) begin
      x_q   <= GAIN_Q30;
      y_q   <= '0;
      z_q   <= zf;
      neg_q <= negf;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_q24(iter_q);
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_q24(iter_q);
      end
    end else if (rnd_q) begin
      cos_q <= neg_q ? -xr[DW-1:0] : xr[DW-1:0];
      sin_q <= neg_q ? -yr[DW-1:0] : yr[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

// File: rtl/rts_mac.sv
`timescale 1ns / 1ps
module rts_mac import rts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mac_ctl_t              ctl_i,
  input  logic signed [OPW-1:0] a_i,
  input  logic signed [OPW-1:0] b_i,
  output mac_ctl_t              wr_o,
  output logic signed [DW-1:0]  res_o
);

  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(64'sh7fffffff);
  localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - 1;

  mac_ctl_t               ctl_q;
  logic signed [ACCW-1:0] prod_q, acc_q, prod_d, sum, rnd;

  assign prod_d = a_i * b_i;
  assign sum    = (ctl_q.first ? '0 : acc_q) + prod_q;
  // round half up, then clamp to the word
  assign rnd    = (sum + ACCW'(32768)) >>> 16;

  always_comb begin
    if (rnd > SAT_HI) begin
      res_o = SAT_HI[DW-1:0];
    end else if (rnd < SAT_LO) begin
      res_o = SAT_LO[DW-1:0];
    end else begin
      res_o = rnd[DW-1:0];
    end
  end

  always_comb begin
    wr_o     = ctl_q;
    wr_o.vld = ctl_q.vld && ctl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= prod_d;
    end
    if (ctl_q.vld) begin
      acc_q <= sum;
    end
  end

endmodule
